// ===== rtl/b2r_pkg.sv =====
// shared types and constants for the bmp24 to rgb565 stream converter
`default_nettype none
package b2r_pkg;
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_BADFMT = 2'd2;
  localparam logic [1:0] KIND_OFFSCR = 2'd3;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_SCREEN_W = 2'd2;
  localparam logic [1:0] REG_SCREEN_H = 2'd3;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] PIXEL_BITS    = 16'd24;
  localparam logic [12:0] SCREEN_LIMIT  = 13'd4096;
  localparam logic [31:0] HEADER_LAST   = 32'd33;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] color_word;
    logic [11:0] screen_col;
    logic [11:0] screen_row;
  } result_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;
endpackage
`default_nettype wire

// ===== rtl/b2r_front.sv =====
// front end: header parse, row walk and clipping of the byte stream
`default_nettype none
module b2r_front
  import b2r_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  file_byte,
  input  wire logic        start_of_file,
  input  wire logic [11:0] origin_x,
  input  wire logic [11:0] origin_y,
  input  wire logic [12:0] screen_width,
  input  wire logic [12:0] screen_height,
  output logic             res_valid,
  output result_t          res,
  input  wire logic        res_ready
);
  localparam int DW = $clog2(MAX_DIM + 1);

  phase_t       phase;
  logic [31:0]  byte_count, header_shift, data_offset;
  logic [DW-1:0] image_width, image_height, visible_width, visible_height;
  logic [DW-1:0] file_row, file_col;
  logic         bottom_up;
  logic [1:0]   byte_in_pixel, pad_left;
  logic [15:0]  bg_hold;

  logic [12:0]  eff_w, eff_h;
  logic         off;
  logic [31:0]  v, negv, hmag;
  logic [12:0]  room_w, room_h;
  logic [DW-1:0] vw_n, vh_n, row_idx;
  logic [15:0]  rgb, swapped;
  logic         fire;
  logic [7:0]   r;

  assign in_ready = !res_valid || res_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    eff_w = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
    eff_h = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
    off   = ({1'b0, origin_x} >= eff_w) || ({1'b0, origin_y} >= eff_h);
    v     = {file_byte, header_shift[31:8]};
    negv  = ~v + 32'd1;
    hmag  = v[31] ? negv : v;
    room_w = eff_w - {1'b0, origin_x};
    room_h = eff_h - {1'b0, origin_y};
    vw_n  = ({19'd0, image_width} < {19'd0, room_w}) ? image_width : DW'(room_w);
    vh_n  = ({19'd0, image_height} < {19'd0, room_h}) ? image_height : DW'(room_h);
    r     = file_byte;
    rgb   = {r[7:3], bg_hold[15:10], bg_hold[7:3]};
    swapped = {rgb[7:0], rgb[15:8]};
    row_idx = bottom_up ? (image_height - DW'(1) - file_row) : file_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      res_valid <= 1'b0;
      bottom_up <= 1'b1;
    end else if (fire) begin : step
      phase_t ph;
      logic [31:0] bc;
      logic [31:0] n;
      logic [DW-1:0] fc;
      logic [DW-1:0] fr;
      logic em;
      ph = phase;
      bc = byte_count;
      em = 1'b0;
      if (start_of_file) begin
        ph = PH_HEADER;
        bc = 32'd0;
        bottom_up <= 1'b1;
        file_row <= '0;
        file_col <= '0;
        byte_in_pixel <= 2'd0;
        pad_left <= 2'd0;
        if (off) begin
          ph = PH_DONE;
          em = 1'b1;
          res <= '{KIND_OFFSCR, 16'd0, 12'd0, 12'd0};
        end
      end
      n = bc;
      if (ph == PH_SKIP && bc < data_offset) begin
        byte_count <= bc + 32'd1;
      end else begin
        if (ph == PH_SKIP) ph = PH_PIXEL;
        unique case (ph)
          PH_HEADER: begin
            header_shift <= v;
            byte_count <= n + 32'd1;
            if (n == 32'd1 && v[31:16] != BMP_SIGNATURE) begin
              ph = PH_DONE;
              em = 1'b1; res <= '{KIND_BADFMT, 16'd0, 12'd0, 12'd0};
            end
            if (n == 32'd13) data_offset <= (v < 32'd34) ? 32'd34 : v;
            if (n == 32'd21) begin
              if (v < 32'd1 || v > 32'(MAX_DIM)) begin
                ph = PH_DONE;
                em = 1'b1; res <= '{KIND_BADFMT, 16'd0, 12'd0, 12'd0};
              end
              image_width <= DW'(v);
            end
            if (n == 32'd25) begin
              bottom_up <= !v[31];
              if (hmag < 32'd1 || hmag > 32'(MAX_DIM)) begin
                ph = PH_DONE;
                em = 1'b1; res <= '{KIND_BADFMT, 16'd0, 12'd0, 12'd0};
              end
              image_height <= DW'(hmag);
            end
            if ((n == 32'd27 && v[31:16] != 16'd1) ||
                (n == 32'd29 && v[31:16] != PIXEL_BITS)) begin
              ph = PH_DONE;
              em = 1'b1; res <= '{KIND_BADFMT, 16'd0, 12'd0, 12'd0};
            end
            if (n == HEADER_LAST) begin
              ph = PH_DONE;
              em = 1'b1;
              if (v != 32'd0) res <= '{KIND_BADFMT, 16'd0, 12'd0, 12'd0};
              else if (off) res <= '{KIND_OFFSCR, 16'd0, 12'd0, 12'd0};
              else begin
                ph = PH_SKIP;
                visible_width <= vw_n;
                visible_height <= vh_n;
                res <= '{KIND_WINDOW, 16'd0, 12'(origin_x + 12'(vw_n) - 12'd1),
                         12'(origin_y + 12'(vh_n) - 12'd1)};
              end
            end
          end
          PH_PAD: begin
            pad_left <= pad_left - 2'd1;
            if (pad_left == 2'd1) begin
              fr = file_row + DW'(1);
              file_row <= fr;
              ph = (fr >= image_height) ? PH_DONE : PH_PIXEL;
            end
          end
          PH_PIXEL: begin
            if (byte_in_pixel == 2'd0) begin
              bg_hold[7:0] <= file_byte; byte_in_pixel <= 2'd1;
            end else if (byte_in_pixel == 2'd1) begin
              bg_hold[15:8] <= file_byte; byte_in_pixel <= 2'd2;
            end else begin
              byte_in_pixel <= 2'd0;
              fc = file_col + DW'(1);
              file_col <= (fc >= image_width) ? '0 : fc;
              if (fc >= image_width) begin
                pad_left <= image_width[1:0];
                if (image_width[1:0] != 2'd0) ph = PH_PAD;
                else begin
                  fr = file_row + DW'(1);
                  file_row <= fr;
                  ph = (fr >= image_height) ? PH_DONE : PH_PIXEL;
                end
              end
              if (file_col < visible_width && row_idx < visible_height) begin
                em = 1'b1;
                res <= '{KIND_PIXEL, swapped, 12'(origin_x + 12'(file_col)),
                         12'(origin_y + 12'(row_idx))};
              end
            end
          end
          default: ;
        endcase
      end
      res_valid <= em;
      phase <= ph;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !in_ready)
    else $error("accepted while result stalled");
  a_pad_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAD |-> pad_left != 2'd0)
    else $error("pad phase with no pad left");
endmodule
`default_nettype wire

// ===== rtl/b2r_queue.sv =====
// two-entry result queue between front end and output channel
`default_nettype none
module b2r_queue
  import b2r_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  result_t   wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output result_t   rd_data
);
  result_t     mem [2];
  logic        wp, rp;
  logic [1:0]  count;
  logic        wr, rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> wp == rp)
    else $error("empty queue pointers differ");
  a_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> wp == rp)
    else $error("full queue pointers differ");
endmodule
`default_nettype wire

// ===== rtl/bmp24_to_rgb565_stream.sv =====
// top level of the bmp24 to rgb565 stream converter
// Takes a 24-bit BMP file one byte a cycle unless results back up, checks
// the header, reports the clipped window (kind 1) or a format or origin
// fault (kinds 2, 3), then gives one swapped RGB565 pixel result for every
// visible pixel on its third byte. A byte is accepted each cycle unless a
// result waits on a full two-entry queue, which rides out brief output stalls.
`default_nettype none
module bmp24_to_rgb565_stream
  import b2r_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  file_byte,
  input  wire logic        start_of_file,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      color_word,
  output logic [11:0]      screen_col,
  output logic [11:0]      screen_row
);
  logic [11:0] origin_x, origin_y;
  logic [12:0] screen_width, screen_height;
  logic        f_valid, f_ready;
  result_t     f_res, q_res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= 12'd0; origin_y <= 12'd0;
      screen_width <= 13'd240; screen_height <= 13'd320;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data[11:0];
        REG_ORIGIN_Y: origin_y <= cfg_data[11:0];
        REG_SCREEN_W: screen_width <= cfg_data;
        REG_SCREEN_H: screen_height <= cfg_data;
      endcase
    end
  end

  b2r_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst, .in_valid, .in_ready, .file_byte, .start_of_file,
    .origin_x, .origin_y, .screen_width, .screen_height,
    .res_valid(f_valid), .res(f_res), .res_ready(f_ready)
  );

  b2r_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_res),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(q_res)
  );

  assign kind       = q_res.kind;
  assign color_word = q_res.color_word;
  assign screen_col = q_res.screen_col;
  assign screen_row = q_res.screen_row;
endmodule
`default_nettype wire
